// ===== rtl/tti_pkg.sv =====
// Shared types, constants and character helpers for the text-to-integer parser.
// No dependencies; imported by tti_step, text_to_integer_parser and the testbench.
package tti_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CH_W            = 8;
    localparam int BASE_W          = 6;

    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] BASE_INVALID = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT     = 6'd36;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7a;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5a;
    localparam logic [CH_W-1:0] CH_X     = 8'h78;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;

    typedef enum logic [3:0] {
        PH_WS     = 4'b0001,
        PH_SIGNED = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic              neg;
        logic [BASE_W-1:0] base;
    } ctrl_t;

    localparam ctrl_t CTRL_CLEAR = '{phase: PH_WS, neg: 1'b0, base: BASE_AUTO};

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Digit value of a character, NO_DIGIT when it is none.
    function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] t;
        t = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            t = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            t = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            t = c - CH_UA + 8'd10;
        end else begin
            t = {2'b00, NO_DIGIT};
        end
        return t[BASE_W-1:0];
    endfunction

endpackage

// ===== rtl/text_to_integer_parser.sv =====
// Streaming strtol-style parser: one character per beat in, one result per parse out.
// Throughput: 1 character per cycle unless a result waits on m_axis_tready; multiply-add is combinational.
// A character is held in an input register; the step logic writes the result register.
// Reset (aresetn low, synchronous) clears the parse state, base_mode and both valids.
// Depends on tti_pkg and tti_step.
module text_to_integer_parser import tti_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [BASE_W-1:0]     cfg_wr_data,     // base_mode
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CH_W-1:0]       s_axis_tdata,    // [7:0] ch
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // value from bit 0, then consumed_count, zero padded to whole bytes
    output logic [((VALUE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                  m_axis_tuser     // bad_base
);

    localparam int DATA_W = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

    logic [BASE_W-1:0]      base_mode_reg;
    logic                   in_valid_reg;
    logic [CH_W-1:0]        ch_reg;
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   bad_reg;

    logic                   step_emit;
    logic                   step_bad;
    logic [VALUE_WIDTH-1:0] step_value;
    logic [COUNT_WIDTH-1:0] step_count;
    logic                   consume;
    logic                   s_accept;

    tti_step #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .ch        (ch_reg),
        .base_mode (base_mode_reg),
        .ctrl      (ctrl_reg),
        .acc       (acc_reg),
        .cnt       (cnt_reg),
        .ctrl_next (ctrl_next),
        .acc_next  (acc_next),
        .cnt_next  (cnt_next),
        .emit      (step_emit),
        .bad       (step_bad),
        .res_value (step_value),
        .res_count (step_count)
    );

    // advance the held beat unless it produces a result that has nowhere to go
    assign consume       = in_valid_reg && (!step_emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_mode_reg <= BASE_AUTO;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= CTRL_CLEAR;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_mode_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                ctrl_reg <= ctrl_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
            end
            if (consume && step_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg <= s_axis_tdata;
        end
        if (consume && step_emit) begin
            value_reg <= step_value;
            count_reg <= step_count;
            bad_reg   <= step_bad;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'({count_reg, value_reg});
    assign m_axis_tuser  = bad_reg;

    // a bad-base result always carries zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && bad_reg |-> value_reg == '0 && count_reg == '0)
        else $error("bad_base result with nonzero payload");

    // nothing is accumulated before a base is latched
    a_ws_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.phase == PH_WS |-> acc_reg == '0)
        else $error("accumulator nonzero while skipping whitespace");

    // parse state moves only when a held beat is consumed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !consume |=> $stable(ctrl_reg) && $stable(acc_reg) && $stable(cnt_reg))
        else $error("parse state changed without a consumed beat");

    // an emitting beat always lands in the result register
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && step_emit |=> out_valid_reg)
        else $error("emitted result lost");

endmodule

// ===== rtl/tti_step.sv =====
// Next-state and result logic for one character of the parser.
// Depends on tti_pkg; instantiated by text_to_integer_parser.
module tti_step import tti_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic [CH_W-1:0]        ch,
    input  logic [BASE_W-1:0]      base_mode,
    input  ctrl_t                  ctrl,
    input  logic [VALUE_WIDTH-1:0] acc,
    input  logic [COUNT_WIDTH-1:0] cnt,
    output ctrl_t                  ctrl_next,
    output logic [VALUE_WIDTH-1:0] acc_next,
    output logic [COUNT_WIDTH-1:0] cnt_next,
    output logic                   emit,
    output logic                   bad,
    output logic [VALUE_WIDTH-1:0] res_value,
    output logic [COUNT_WIDTH-1:0] res_count
);

    localparam int PROD_W = VALUE_WIDTH + BASE_W;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [BASE_W-1:0]      digit;
    logic [BASE_W-1:0]      take_base;
    logic [PROD_W-1:0]      prod;
    logic                   take;
    logic                   bad_cfg;
    logic                   auto_or_hex;

    assign cnt_inc     = (cnt == '1) ? cnt : cnt + 1'b1;
    assign digit       = digit_of(ch);
    assign bad_cfg     = (base_mode == BASE_INVALID) || (base_mode > BASE_MAX);
    assign auto_or_hex = (base_mode == BASE_AUTO) || (base_mode == BASE_HEX);
    assign prod        = PROD_W'(acc) * PROD_W'(take_base);

    always_comb begin
        ctrl_next = ctrl;
        acc_next  = acc;
        cnt_next  = cnt;
        emit      = 1'b0;
        bad       = 1'b0;
        take      = 1'b0;
        take_base = ctrl.base;
        unique case (ctrl.phase) inside
            PH_WS, PH_SIGNED: begin
                if (bad_cfg) begin
                    emit = 1'b1;
                    bad  = 1'b1;
                end else if (ctrl.phase == PH_WS && is_space(ch)) begin
                    cnt_next = cnt_inc;
                end else if (ctrl.phase == PH_WS && (ch == CH_MINUS || ch == CH_PLUS)) begin
                    ctrl_next.neg   = (ch == CH_MINUS);
                    ctrl_next.phase = PH_SIGNED;
                    cnt_next        = cnt_inc;
                end else if (auto_or_hex && ch == CH_0) begin
                    ctrl_next.base  = (base_mode == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    ctrl_next.phase = PH_ZERO;
                    acc_next        = '0;
                    cnt_next        = cnt_inc;
                end else begin
                    take_base      = (base_mode == BASE_AUTO) ? BASE_DEC : base_mode;
                    ctrl_next.base = take_base;
                    take           = 1'b1;
                end
            end
            PH_ZERO: begin
                // lower-case x only turns a leading zero into a hex prefix
                if (ch == CH_X) begin
                    ctrl_next.base  = BASE_HEX;
                    ctrl_next.phase = PH_DIGITS;
                    cnt_next        = cnt_inc;
                end else begin
                    take = 1'b1;
                end
            end
            PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
                take = 1'b1;
            end
        endcase

        if (take) begin
            if (digit < take_base) begin
                acc_next        = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit);
                cnt_next        = cnt_inc;
                ctrl_next.phase = PH_DIGITS;
            end else begin
                emit = 1'b1;
            end
        end

        // an ending character is dropped and the parse starts over
        if (emit) begin
            ctrl_next = CTRL_CLEAR;
            acc_next  = '0;
            cnt_next  = '0;
        end
    end

    assign res_value = bad ? '0 : (ctrl.neg ? VALUE_WIDTH'(-acc) : acc);
    assign res_count = bad ? '0 : cnt;

endmodule

// ===== test/text_to_integer_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_to_integer_parser: a directed table with pinned results,
// then random number strings under many base settings, checked against a local parser.
// Depends on tti_pkg and the parser RTL only.
module text_to_integer_parser_tb;
    import tti_pkg::*;

    localparam int VALUE_W       = VALUE_WIDTH_DEF;
    localparam int COUNT_W       = COUNT_WIDTH_DEF;
    localparam int DATA_W        = ((VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int RANDOM_CHARS  = 1150;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic               bad;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
    } parse_result_t;

    typedef struct packed {
        logic              set_base;
        logic [BASE_W-1:0] base;
        logic [CH_W-1:0]   ch;
        logic              pinned;
        parse_result_t     want;
    } script_row_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [BASE_W-1:0] cfg_wr_data   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CH_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;

    // local parser state
    phase_t             scan_phase   = PH_WS;
    logic               minus_taken  = 1'b0;
    logic [BASE_W-1:0]  radix        = BASE_AUTO;
    logic [VALUE_W-1:0] total        = '0;
    logic [COUNT_W-1:0] run_len      = '0;
    logic [BASE_W-1:0]  base_setting = BASE_AUTO;

    parse_result_t awaited_numbers[$];
    parse_result_t oldest;
    script_row_t   script[$];
    logic          calm = 1'b0;
    int            chars_sent      = 0;
    int            numbers_checked = 0;
    int            base_writes     = 0;
    int            mismatches      = 0;
    int            cycle_count     = 0;

    text_to_integer_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        case (c)
            CH_SPACE, CH_TAB, 8'h0a, 8'h0b, 8'h0c, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int digit_val(input logic [CH_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return c - CH_0;
        if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
        if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
        return NO_DIGIT;
    endfunction

    function automatic void count_char();
        if (run_len != {COUNT_W{1'b1}}) run_len = run_len + 1'b1;
    endfunction

    function automatic parse_result_t close_parse(input logic bad);
        parse_result_t r;
        r = '0;
        r.bad = bad;
        if (!bad) begin
            r.value = minus_taken ? -total : total;
            r.count = run_len;
        end
        scan_phase  = PH_WS;
        minus_taken = 1'b0;
        radix       = BASE_AUTO;
        total       = '0;
        run_len     = '0;
        return r;
    endfunction

    // Advance the local parser by one character; returns 1 when a number is emitted.
    function automatic logic advance_parser(input logic [CH_W-1:0] c, output parse_result_t r);
        int d;
        r = '0;
        if (scan_phase == PH_WS || scan_phase == PH_SIGNED) begin
            // no radix latched yet, so the register decides
            if (base_setting == BASE_INVALID || base_setting > BASE_MAX) begin
                r = close_parse(1'b1);
                return 1'b1;
            end
            if (scan_phase == PH_WS && is_blank(c)) begin
                count_char();
                return 1'b0;
            end
            if (scan_phase == PH_WS && (c == CH_MINUS || c == CH_PLUS)) begin
                minus_taken = (c == CH_MINUS);
                count_char();
                scan_phase = PH_SIGNED;
                return 1'b0;
            end
            if ((base_setting == BASE_AUTO || base_setting == BASE_HEX) && c == CH_0) begin
                radix = (base_setting == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                total = '0;
                count_char();
                scan_phase = PH_ZERO;
                return 1'b0;
            end
            radix = (base_setting == BASE_AUTO) ? BASE_DEC : base_setting;
        end else if (scan_phase == PH_ZERO && c == CH_X) begin
            radix = BASE_HEX;
            count_char();
            scan_phase = PH_DIGITS;
            return 1'b0;
        end
        d = digit_val(c);
        if (d < radix) begin
            total = total * radix + d;
            count_char();
            scan_phase = PH_DIGITS;
            return 1'b0;
        end
        r = close_parse(1'b0);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, want %0h (number %0d)", what, got, want,
                 numbers_checked);
        mismatches++;
    endtask

    // Hold the beat until it is taken, then advance the local parser.
    task automatic send_char(input logic [CH_W-1:0] c, input logic pin,
                             input parse_result_t want);
        parse_result_t got;
        logic          emitted;
        if (!calm && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) @(posedge aclk);
        emitted = advance_parser(c, got);
        if (emitted || pin) awaited_numbers.push_back(pin ? want : got);
        chars_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited_numbers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        base_setting = b;
        base_writes++;
    endtask

    task automatic step_row(input logic set, input logic [BASE_W-1:0] b,
                            input logic [CH_W-1:0] c);
        script_row_t row;
        row          = '0;
        row.set_base = set;
        row.base     = b;
        row.ch       = c;
        script.push_back(row);
    endtask

    task automatic check_row(input logic set, input logic [BASE_W-1:0] b,
                             input logic [CH_W-1:0] c, input logic [VALUE_W-1:0] value,
                             input logic [COUNT_W-1:0] count, input logic bad);
        script_row_t row;
        row            = '0;
        row.set_base   = set;
        row.base       = b;
        row.ch         = c;
        row.pinned     = 1'b1;
        row.want.value = value;
        row.want.count = count;
        row.want.bad   = bad;
        script.push_back(row);
    endtask

    // One string: blanks, sign, prefix, mostly in-range digits, then a final byte.
    // A cut string stops short so the next base write lands mid-parse.
    task automatic send_number(input logic cut);
        logic [CH_W-1:0] text[$];
        int              span;
        int              k;
        int              d;
        span = BASE_DEC;
        repeat ($urandom_range(0, 3)) begin
            k = $urandom_range(0, 6);
            text.push_back(k > 4 ? CH_SPACE : CH_W'(CH_TAB + k));
        end
        k = $urandom_range(0, 3);
        if (k == 0) text.push_back(CH_MINUS);
        else if (k == 1) text.push_back(CH_PLUS);
        if (base_setting == BASE_AUTO || base_setting == BASE_HEX) begin
            k = $urandom_range(0, 3);
            if (k == 0) begin
                text.push_back(CH_0);
                text.push_back(CH_X);
                span = 16;
            end else if (k == 1 && base_setting == BASE_AUTO) begin
                text.push_back(CH_0);
                span = 8;
            end else if (base_setting == BASE_HEX) begin
                span = 16;
            end
        end else if (base_setting >= 2 && base_setting <= BASE_MAX) begin
            span = base_setting;
        end
        repeat ($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 12)) begin
            d = $urandom_range(0, span - 1);
            if ($urandom_range(0, 19) == 0) text.push_back(CH_W'($urandom_range(0, 255)));
            else if (d < 10) text.push_back(CH_W'(CH_0 + d));
            else text.push_back(CH_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10));
        end
        text.push_back($urandom_range(0, 1) ? 8'h00 : CH_W'($urandom_range(0, 255)));
        if (cut && text.size() > 1) begin
            k = $urandom_range(1, text.size() - 1);
            while (text.size() > k) void'(text.pop_back());
        end
        foreach (text[i]) send_char(text[i], 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (awaited_numbers.size() == 0) begin
                report_mismatch("result with none expected", m_axis_tdata[VALUE_W-1:0], 0);
            end else begin
                oldest = awaited_numbers.pop_front();
                if (m_axis_tdata[VALUE_W-1:0] !== oldest.value)
                    report_mismatch("value", m_axis_tdata[VALUE_W-1:0], oldest.value);
                if (m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W] !== oldest.count)
                    report_mismatch("consumed_count", m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W],
                                    oldest.count);
                if (m_axis_tuser !== oldest.bad)
                    report_mismatch("bad_base", m_axis_tuser, oldest.bad);
                numbers_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d numbers outstanding", cycle_count,
                     awaited_numbers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [BASE_W-1:0] next_base;
        int                random_start;
        int                phase_no;
        int                strings_left;

        // reset value of the base register is automatic; NUL alone gives zero
        check_row(1'b0, BASE_AUTO, 8'h00, 32'd0, 16'd0, 1'b0);
        step_row(1'b0, BASE_AUTO, CH_SPACE);
        step_row(1'b0, BASE_AUTO, CH_TAB);
        step_row(1'b0, BASE_AUTO, CH_MINUS);
        step_row(1'b0, BASE_AUTO, CH_0);
        step_row(1'b0, BASE_AUTO, "1");
        step_row(1'b0, BASE_AUTO, "7");
        check_row(1'b0, BASE_AUTO, "8", -32'sd15, 16'd6, 1'b0);
        // hex prefix with no hex digit after it
        step_row(1'b0, BASE_AUTO, CH_0);
        step_row(1'b0, BASE_AUTO, CH_X);
        check_row(1'b0, BASE_AUTO, "g", 32'd0, 16'd2, 1'b0);
        // octal latched by the leading zero survives a base write
        step_row(1'b0, BASE_AUTO, CH_0);
        step_row(1'b1, 6'd2, "7");
        check_row(1'b0, 6'd2, 8'hff, 32'd7, 16'd2, 1'b0);
        check_row(1'b1, BASE_INVALID, "5", 32'd0, 16'd0, 1'b1);
        step_row(1'b1, BASE_MAX, "Z");
        step_row(1'b0, BASE_MAX, "z");
        check_row(1'b0, BASE_MAX, 8'h00, 32'd1295, 16'd2, 1'b0);
        // invalid base after a sign is still caught
        step_row(1'b1, 6'd2, CH_PLUS);
        check_row(1'b1, 6'd63, "1", 32'd0, 16'd0, 1'b1);
        step_row(1'b1, BASE_HEX, CH_MINUS);
        step_row(1'b0, BASE_HEX, "8");
        repeat (7) step_row(1'b0, BASE_HEX, CH_0);
        check_row(1'b0, BASE_HEX, 8'h00, 32'h8000_0000, 16'd9, 1'b0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].set_base) write_base(script[i].base);
            send_char(script[i].ch, script[i].pinned, script[i].want);
        end

        random_start = chars_sent;
        phase_no     = 0;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            calm = (chars_sent - random_start >= 500) && (chars_sent - random_start < 750);
            case (phase_no)
                0: next_base = BASE_AUTO;
                1: next_base = BASE_HEX;
                2: next_base = BASE_DEC;
                3: next_base = BASE_OCT;
                4: next_base = 6'd2;
                5: next_base = BASE_MAX;
                6: next_base = BASE_INVALID;
                7: next_base = 6'd63;
                8: next_base = 6'd37;
                default: begin
                    if ($urandom_range(0, 4) == 0) next_base = BASE_W'($urandom_range(0, 63));
                    else if ($urandom_range(0, 2) == 0) next_base = BASE_AUTO;
                    else next_base = BASE_W'($urandom_range(2, 36));
                end
            endcase
            write_base(next_base);
            strings_left = $urandom_range(3, 30);
            while (strings_left > 0) begin
                strings_left--;
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_char(CH_W'($urandom_range(0, 255)), 1'b0, '0);
                end else begin
                    send_number(strings_left == 0 && $urandom_range(0, 2) == 0);
                end
            end
            phase_no++;
        end
        calm = 1'b0;

        wait_idle();
        $display("sent %0d characters under %0d base writes, checked %0d numbers",
                 chars_sent, base_writes, numbers_checked);
        $display("covered sign, prefix, octal/hex/base-36 digits, bad bases and wrap");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
